[rtl/pnt_pkg.sv]
// Shared types, codes and constants of the principal name tokenizer.
package pnt_pkg;

    localparam int MAX_COMPONENTS_DEF = 15;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [7:0] CH_REALM_SEP = 8'h40; // '@'
    localparam logic [7:0] CH_COMP_SEP  = 8'h2F; // '/'
    localparam logic [7:0] CH_ESCAPE    = 8'h5C; // backslash

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_BOUNDARY = 2'd1;
    localparam logic [1:0] KIND_NONE     = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_TRAIL_ESC    = 3'd1;
    localparam logic [2:0] ST_EMPTY_REALM  = 3'd2;
    localparam logic [2:0] ST_SECOND_REALM = 3'd3;
    localparam logic [2:0] ST_TOO_MANY     = 3'd4;

    // Byte classes decided by the front end
    typedef enum logic [2:0] {
        CLS_DATA,
        CLS_ESCAPED,
        CLS_PREFIX,
        CLS_SLASH,
        CLS_AT
    } pnt_cls_t;

    typedef struct packed {
        pnt_cls_t   cls;
        logic [7:0] byte_val;
        logic       fin;
    } pnt_item_t;

    function automatic logic [7:0] decode_escaped(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E:   r = 8'h0A; // n -> newline
            8'h74:   r = 8'h09; // t -> tab
            8'h62:   r = 8'h08; // b -> backspace
            8'h30:   r = 8'h00; // 0 -> zero
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] note_error(input logic [2:0] err, input logic [2:0] code);
        return (err == ST_OK) ? code : err;
    endfunction

endpackage

[rtl/principal_name_tokenizer_core.sv]
// Top level of the principal name tokenizer: front end, queue and back end.
//
// Input stream: one byte of a principal name per transfer on s_tdata[7:0],
// with s_tlast high on the final byte of each name. Output stream: one
// result per input byte. m_tuser carries the kind (data, boundary, none),
// m_tdata the decoded byte, component index, realm flag, sticky status and
// component count; m_tlast marks the result for the final byte, on which
// status and count are final. Realm bytes carry component index 0.
//
// Throughput is one byte per cycle while the receiver does not stall. An input
// transfer reaches m_tvalid through the two-entry queue and then the output
// register of the back end. When the receiver stalls, the output register
// holds its result and the queue absorbs two more bytes before s_tready
// falls; it rises again in the cycle after the stall clears.
//
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result and returns the parser to the start of a name; state also returns
// to that point after every final byte.
module principal_name_tokenizer_core #(
    parameter int MAX_COMPONENTS = pnt_pkg::MAX_COMPONENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // is_final
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [11:8] component, [12] in_realm,
                                   // [15:13] status, [19:16] component_count, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // end_of_name
);

    localparam logic [3:0] COMP_LIMIT = 4'((MAX_COMPONENTS < 15) ? MAX_COMPONENTS : 15);

    pnt_pkg::pnt_item_t push_item;
    pnt_pkg::pnt_item_t head_item;
    logic               q_ready;
    logic               q_push;
    logic               q_pop;
    logic               head_valid;

    logic [7:0] data_byte;
    logic [3:0] component;
    logic       in_realm;
    logic [2:0] status;
    logic [3:0] comp_count;

    // classify bytes and track escapes
    pnt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_char   (s_tdata),
        .s_last   (s_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // decouples front from a stalled back end
    pnt_queue #(
        .DEPTH (pnt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .not_full   (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // name state, errors and result register
    pnt_back #(
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_kind      (m_tuser),
        .m_data_byte (data_byte),
        .m_component (component),
        .m_in_realm  (in_realm),
        .m_last      (m_tlast),
        .m_status    (status),
        .m_count     (comp_count)
    );

    assign m_tdata = {4'd0, comp_count, status, in_realm, component, data_byte};

    // a full queue only arises behind a held result
    a_full_means_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("queue full with no result held");

    // anything but a data byte carries a zero byte
    a_nondata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != pnt_pkg::KIND_DATA) |-> (data_byte == 8'd0))
        else $error("non-data result with a data byte");

    // data inside the realm belongs to component 0
    a_realm_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && in_realm && (m_tuser == pnt_pkg::KIND_DATA) |-> (component == 4'd0))
        else $error("realm data outside component 0");

    // component count stays within its limit
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (comp_count != 4'd0) && (comp_count <= COMP_LIMIT))
        else $error("component count out of range");

endmodule

[rtl/pnt_front.sv]
// Front end: accepts bytes, tracks escapes and classifies each byte.
module pnt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_char,
    input  logic                s_last,
    input  logic                q_ready,
    output logic                q_push,
    output pnt_pkg::pnt_item_t  q_item
);

    logic esc_pending_reg;
    logic esc_pending_next;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        q_item.fin      = s_last;
        q_item.byte_val = s_char;
        esc_pending_next = esc_pending_reg;
        if (esc_pending_reg) begin
            q_item.cls      = pnt_pkg::CLS_ESCAPED;
            q_item.byte_val = pnt_pkg::decode_escaped(s_char);
            esc_pending_next = 1'b0;
        end else if (s_char == pnt_pkg::CH_ESCAPE) begin
            q_item.cls      = pnt_pkg::CLS_PREFIX;
            esc_pending_next = 1'b1;
        end else if (s_char == pnt_pkg::CH_COMP_SEP) begin
            q_item.cls = pnt_pkg::CLS_SLASH;
        end else if (s_char == pnt_pkg::CH_REALM_SEP) begin
            q_item.cls = pnt_pkg::CLS_AT;
        end else begin
            q_item.cls = pnt_pkg::CLS_DATA;
        end
        // a new name starts after the final byte
        if (s_last) begin
            esc_pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_pending_reg <= 1'b0;
        end else if (q_push) begin
            esc_pending_reg <= esc_pending_next;
        end
    end

endmodule

[rtl/pnt_queue.sv]
// Short queue of classified bytes between the front and back ends.
module pnt_queue #(
    parameter int DEPTH = pnt_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pnt_pkg::pnt_item_t  push_item,
    output logic                not_full,
    input  logic                pop,
    output logic                head_valid,
    output pnt_pkg::pnt_item_t  head_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    pnt_pkg::pnt_item_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_full   = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/pnt_back.sv]
// Back end: realm, component and error state, and the result register.
module pnt_back #(
    parameter int MAX_COMPONENTS = pnt_pkg::MAX_COMPONENTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  pnt_pkg::pnt_item_t  head_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [1:0]          m_kind,
    output logic [7:0]          m_data_byte,
    output logic [3:0]          m_component,
    output logic                m_in_realm,
    output logic                m_last,
    output logic [2:0]          m_status,
    output logic [3:0]          m_count
);

    localparam logic [3:0] COMP_LIMIT = 4'((MAX_COMPONENTS < 15) ? MAX_COMPONENTS : 15);

    logic       realm_reg, realm_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] err_reg, err_next;
    logic       valid_reg, valid_next;

    logic [1:0] kind_reg, kind_next;
    logic [7:0] data_reg, data_next;
    logic [3:0] comp_reg, comp_next;
    logic       inr_reg;
    logic       last_reg;
    logic [2:0] status_reg;
    logic [3:0] count_reg;

    logic [2:0] err_at;
    logic [3:0] cur_comp;

    assign pop      = head_valid && (!valid_reg || m_tready);
    assign cur_comp = realm_reg ? 4'd0 : idx_reg;

    always_comb begin
        realm_next = realm_reg;
        idx_next   = idx_reg;
        err_next   = err_reg;
        kind_next  = pnt_pkg::KIND_DATA;
        data_next  = 8'd0;
        comp_next  = cur_comp;
        err_at     = head_item.fin ? pnt_pkg::note_error(err_reg, pnt_pkg::ST_EMPTY_REALM)
                                   : err_reg;
        case (head_item.cls)
            pnt_pkg::CLS_ESCAPED,
            pnt_pkg::CLS_DATA: begin
                data_next = head_item.byte_val;
            end
            pnt_pkg::CLS_PREFIX: begin
                kind_next = pnt_pkg::KIND_NONE;
                if (head_item.fin) begin
                    err_next = pnt_pkg::note_error(err_reg, pnt_pkg::ST_TRAIL_ESC);
                end
            end
            pnt_pkg::CLS_SLASH: begin
                if (realm_reg) begin
                    // slash is plain realm data
                    data_next = head_item.byte_val;
                end else begin
                    kind_next = pnt_pkg::KIND_BOUNDARY;
                    if (idx_reg >= COMP_LIMIT) begin
                        err_next = pnt_pkg::note_error(err_reg, pnt_pkg::ST_TOO_MANY);
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                    comp_next = idx_next;
                end
            end
            pnt_pkg::CLS_AT: begin
                comp_next = 4'd0;
                if (realm_reg) begin
                    kind_next = pnt_pkg::KIND_NONE;
                    err_next  = pnt_pkg::note_error(err_at, pnt_pkg::ST_SECOND_REALM);
                end else begin
                    kind_next  = pnt_pkg::KIND_BOUNDARY;
                    realm_next = 1'b1;
                    err_next   = err_at;
                end
            end
            default: begin
                data_next = head_item.byte_val;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            realm_reg <= 1'b0;
            idx_reg   <= 4'd1;
            err_reg   <= pnt_pkg::ST_OK;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                if (head_item.fin) begin
                    realm_reg <= 1'b0;
                    idx_reg   <= 4'd1;
                    err_reg   <= pnt_pkg::ST_OK;
                end else begin
                    realm_reg <= realm_next;
                    idx_reg   <= idx_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg   <= kind_next;
            data_reg   <= data_next;
            comp_reg   <= comp_next;
            inr_reg    <= realm_next;
            last_reg   <= head_item.fin;
            status_reg <= err_next;
            count_reg  <= idx_next;
        end
    end

    assign m_tvalid    = valid_reg;
    assign m_kind      = kind_reg;
    assign m_data_byte = data_reg;
    assign m_component = comp_reg;
    assign m_in_realm  = inr_reg;
    assign m_last      = last_reg;
    assign m_status    = status_reg;
    assign m_count     = count_reg;

endmodule

[tb/pnt_stream_checker.sv]
// Scoreboard for the principal name tokenizer: predicts each result and compares it.
module pnt_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          outstanding,
    output int          results_checked,
    output int          names_closed,
    output int          names_flagged
);
    timeunit 1ns;
    timeprecision 1ps;
    import pnt_pkg::*;

    localparam logic [3:0] COMP_LIMIT =
        (MAX_COMPONENTS_DEF < 15) ? 4'(MAX_COMPONENTS_DEF) : 4'd15;

    // escape letters and what they decode to
    localparam logic [7:0] ESC_LF_KEY   = "n";
    localparam logic [7:0] ESC_TAB_KEY  = "t";
    localparam logic [7:0] ESC_BS_KEY   = "b";
    localparam logic [7:0] ESC_NUL_KEY  = "0";
    localparam logic [7:0] CHR_LF       = 8'h0A;
    localparam logic [7:0] CHR_TAB      = 8'h09;
    localparam logic [7:0] CHR_BS       = 8'h08;
    localparam logic [7:0] CHR_NUL      = 8'h00;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [3:0] component;
        logic       in_realm;
        logic       end_of_name;
        logic [2:0] status;
        logic [3:0] comp_count;
    } name_result_t;

    logic       escape_armed;
    logic       realm_open;
    logic [3:0] comp_idx;
    logic [2:0] first_error;

    name_result_t expected_results[$];

    function automatic void clear_name_state();
        escape_armed = 1'b0;
        realm_open   = 1'b0;
        comp_idx     = 4'd1;
        first_error  = ST_OK;
    endfunction

    function automatic void latch_error(input logic [2:0] code);
        if (first_error == ST_OK)
            first_error = code;
    endfunction

    function automatic name_result_t tokenise_byte(input logic [7:0] c, input logic fin);
        name_result_t r;
        r = '0;
        r.kind = KIND_DATA;
        if (escape_armed) begin
            escape_armed = 1'b0;
            case (c)
                ESC_LF_KEY:  r.data_byte = CHR_LF;
                ESC_TAB_KEY: r.data_byte = CHR_TAB;
                ESC_BS_KEY:  r.data_byte = CHR_BS;
                ESC_NUL_KEY: r.data_byte = CHR_NUL;
                default:     r.data_byte = c;
            endcase
            r.component = realm_open ? 4'd0 : comp_idx;
        end else if (c == CH_ESCAPE) begin
            escape_armed = 1'b1;
            r.kind = KIND_NONE;
            r.component = realm_open ? 4'd0 : comp_idx;
            if (fin)
                latch_error(ST_TRAIL_ESC);
        end else if (c == CH_COMP_SEP && !realm_open) begin
            r.kind = KIND_BOUNDARY;
            if (comp_idx >= COMP_LIMIT)
                latch_error(ST_TOO_MANY);
            else
                comp_idx = comp_idx + 4'd1;
            r.component = comp_idx;
        end else if (c == CH_REALM_SEP) begin
            // empty realm takes precedence over second realm
            if (fin)
                latch_error(ST_EMPTY_REALM);
            if (realm_open) begin
                latch_error(ST_SECOND_REALM);
                r.kind = KIND_NONE;
            end else begin
                realm_open = 1'b1;
                r.kind = KIND_BOUNDARY;
            end
            r.component = 4'd0;
        end else begin
            r.data_byte = c;
            r.component = realm_open ? 4'd0 : comp_idx;
        end
        r.in_realm    = realm_open;
        r.end_of_name = fin;
        r.status      = first_error;
        r.comp_count  = comp_idx;
        if (fin)
            clear_name_state();
        return r;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    initial begin
        fail_count      = 0;
        outstanding     = 0;
        results_checked = 0;
        names_closed    = 0;
        names_flagged   = 0;
        clear_name_state();
    end

    always @(posedge aclk) begin
        name_result_t want;
        if (!aresetn) begin
            clear_name_state();
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind",            want.kind,        m_tuser);
                    check_field("data_byte",       want.data_byte,   m_tdata[7:0]);
                    check_field("component",       want.component,   m_tdata[11:8]);
                    check_field("in_realm",        want.in_realm,    m_tdata[12]);
                    check_field("end_of_name",     want.end_of_name, m_tlast);
                    check_field("status",          want.status,      m_tdata[15:13]);
                    check_field("component_count", want.comp_count,  m_tdata[19:16]);
                    check_field("tdata padding",   0,                m_tdata[23:20]);
                end
            end
            if (s_tvalid && s_tready) begin
                want = tokenise_byte(s_tdata, s_tlast);
                expected_results.push_back(want);
                if (s_tlast) begin
                    names_closed++;
                    if (want.status != ST_OK)
                        names_flagged++;
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

[tb/principal_name_tokenizer_core_test.sv]
// Top of the tokenizer testbench: clock, reset, byte stimulus, receiver stalls and verdict.
module principal_name_tokenizer_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pnt_pkg::*;

    localparam int TOTAL_BYTES  = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;     // settling margin after the last result is checked
    localparam int HOLD_OFF     = 300;   // long receiver stall, fills the queue

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_in
    logic        s_tlast;   // is_final
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] data_byte, [11:8] component, [12] in_realm,
                            // [15:13] status, [19:16] component_count, rest zero
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        m_tlast;   // end_of_name

    int fail_count;
    int outstanding;
    int results_checked;
    int names_closed;
    int names_flagged;

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_left;
    int bytes_sent;
    int cycle_count;

    principal_name_tokenizer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    pnt_stream_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .names_closed    (names_closed),
        .names_flagged   (names_flagged)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Watchdog: generous bound on the slowest legal run
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off counted down here
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready = 1'b0;
            rx_hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // One byte transfer; entered and left on a falling edge.
    // tvalid drops after each transfer unless the next byte follows straight away.
    task automatic send_byte(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tlast  = fin;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_name(input logic [7:0] nb[$]);
        foreach (nb[i])
            send_byte(nb[i], i == nb.size() - 1);
    endtask

    // Sender pause until the block has returned every result
    task automatic wait_drained();
        while (outstanding != 0)
            @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    // Ordinary name byte: mostly lower-case letters, sometimes any
    // byte that is not one of the three special characters
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(9) < 7)
            return 8'($urandom_range(8'h7A, 8'h61));
        do c = 8'($urandom_range(255));
        while (c == CH_ESCAPE || c == CH_COMP_SEP || c == CH_REALM_SEP);
        return c;
    endfunction

    // Byte following a backslash: the four decoding letters, the specials, or anything
    function automatic logic [7:0] escape_target();
        case ($urandom_range(7))
            0: return "n";
            1: return "t";
            2: return "b";
            3: return "0";
            4: return CH_ESCAPE;
            5: return CH_REALM_SEP;
            6: return CH_COMP_SEP;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_char(ref logic [7:0] nb[$]);
        if ($urandom_range(99) < 15) begin
            nb.push_back(CH_ESCAPE);
            nb.push_back(escape_target());
        end else begin
            nb.push_back(plain_char());
        end
    endtask

    // Mostly well-formed: components split by slashes, optional realm.
    // About one name in ten gets 13 to 18 components, around the component limit.
    task automatic build_wellformed(ref logic [7:0] nb[$]);
        int n_comp;
        int n_chars;
        n_comp = ($urandom_range(9) == 0) ? $urandom_range(18, 13) : $urandom_range(4, 1);
        for (int i = 0; i < n_comp; i++) begin
            if (i != 0)
                nb.push_back(CH_COMP_SEP);
            n_chars = $urandom_range(5, 0);
            for (int j = 0; j < n_chars; j++)
                add_char(nb);
        end
        if ($urandom_range(2) != 0) begin
            nb.push_back(CH_REALM_SEP);
            n_chars = $urandom_range(6, 0);
            // slashes are plain data in the realm; a stray at-sign now and then
            for (int j = 0; j < n_chars; j++) begin
                case ($urandom_range(19))
                    0, 1, 2: nb.push_back(CH_COMP_SEP);
                    3:       nb.push_back(CH_REALM_SEP);
                    default: add_char(nb);
                endcase
            end
        end
        // a trailing backslash now and then
        if ($urandom_range(19) == 0)
            nb.push_back(CH_ESCAPE);
        if (nb.size() == 0)
            nb.push_back(plain_char());
    endtask

    // Noise: short bursts heavy in specials, so broken escapes and realms appear
    task automatic build_noise(ref logic [7:0] nb[$]);
        int len;
        len = $urandom_range(10, 1);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0, 1:    nb.push_back(CH_ESCAPE);
                2:       nb.push_back(CH_COMP_SEP);
                3:       nb.push_back(CH_REALM_SEP);
                default: nb.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    initial begin
        logic [7:0] nb[$];
        int phase_end;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 0;
        bytes_sent   = 0;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed names.
        // Zero byte, slash, escaped newline and zero, realm with a slash in it,
        // escaped at-sign, 0xFF on the final byte.
        send_name('{8'h00, CH_COMP_SEP, CH_ESCAPE, "n", CH_ESCAPE, "0", CH_REALM_SEP,
                    CH_COMP_SEP, CH_ESCAPE, CH_REALM_SEP, 8'hFF});
        // Escaped tab and backspace, then a second realm separator
        send_name('{CH_ESCAPE, "t", CH_ESCAPE, "b", CH_REALM_SEP, "x", CH_REALM_SEP, "y"});
        // Realm separator on the final byte: empty realm
        send_name('{"q", CH_REALM_SEP});
        // Backslash on the final byte: trailing escape
        send_name('{CH_ESCAPE});
        wait_drained();

        // Random names in three back-pressure regimes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 21;
                    rx_idle_pct = 87;
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 21;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // receiver holds off while the sender keeps offering bytes
                    rx_hold_left = HOLD_OFF;
                end
            endcase
            phase_end = bytes_sent + (TOTAL_BYTES - bytes_sent) / (3 - phase);
            while (bytes_sent < phase_end) begin
                nb.delete();
                if ($urandom_range(99) < 80)
                    build_wellformed(nb);
                else
                    build_noise(nb);
                send_name(nb);
            end
            wait_drained();
        end

        $display("Sent %0d bytes as %0d names (%0d ending in an error status);",
                 bytes_sent, names_closed, names_flagged);
        $display("compared %0d results under three stall regimes and a long hold-off.",
                 results_checked);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[principal_name_tokenizer_core.f]
rtl/pnt_pkg.sv
rtl/pnt_front.sv
rtl/pnt_queue.sv
rtl/pnt_back.sv
rtl/principal_name_tokenizer_core.sv
tb/pnt_stream_checker.sv
tb/principal_name_tokenizer_core_test.sv
